### design/bba_pkg.sv
// Shared types, codes and constants for the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int BLOCK_W   = 13;

    localparam logic OP_ALLOC    = 1'b0;
    localparam logic OP_FREE     = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    // address register operations
    typedef logic [2:0] addr_op_t;
    localparam addr_op_t ADDR_HOLD = 3'd0;
    localparam addr_op_t ADDR_ZERO = 3'd1;
    localparam addr_op_t ADDR_REQ  = 3'd2;
    localparam addr_op_t ADDR_TAIL = 3'd3;
    localparam addr_op_t ADDR_INC  = 3'd4;

    // bitmap write data select
    typedef logic [2:0] wr_sel_t;
    localparam wr_sel_t WR_CLEAR = 3'd0;
    localparam wr_sel_t WR_FREE  = 3'd1;
    localparam wr_sel_t WR_MARK0 = 3'd2;
    localparam wr_sel_t WR_TAIL  = 3'd3;
    localparam wr_sel_t WR_HIT   = 3'd4;

    // pending result kinds
    typedef logic [1:0] pend_kind_t;
    localparam pend_kind_t PEND_ZERO = 2'd0;
    localparam pend_kind_t PEND_HIT  = 2'd1;
    localparam pend_kind_t PEND_FULL = 2'd2;

    typedef struct packed {
        logic       req_load;
        addr_op_t   addr_op;
        logic       rd_en;
        logic       wr_en;
        wr_sel_t    wr_sel;
        logic       pend_load;
        pend_kind_t pend_kind;
        logic       out_load;
    } bba_cmd_t;

    typedef struct packed {
        logic req_op;
        logic req_in_range;
        logic addr_last;
        logic chk_last;
        logic word_full;
        logic bit0_set;
        logic has_tail;
        logic out_free;
    } bba_sts_t;

endpackage

`default_nettype wire

### design/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/bba_datapath.sv
// Bitmap storage, address counter, per-word priority encoder and result registers.
`timescale 1ns / 1ps
`default_nettype none

module bba_datapath
    import bba_pkg::*;
#(
    parameter int TOTAL_BLOCKS  = 8192,
    parameter int RESERVED_TAIL = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bba_cmd_t           cmd,
    output bba_sts_t                sts,
    input  wire logic               s_opcode,
    input  wire logic [BLOCK_W-1:0] s_block_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [BLOCK_W-1:0] m_granted_block,
    output logic                    m_status
);

    localparam int WORDS      = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW         = AW + BIT_W;
    localparam int LAST_WORD  = WORDS - 1;
    localparam int TAIL_FIRST = (RESERVED_TAIL >= TOTAL_BLOCKS) ? 0
                                                                : TOTAL_BLOCKS - RESERVED_TAIL;
    localparam int TF_WORD    = TAIL_FIRST / WORD_BITS;
    localparam int TF_BIT     = TAIL_FIRST % WORD_BITS;
    localparam int PAD_BITS   = TOTAL_BLOCKS % WORD_BITS;
    localparam word_t HEAD_MASK = ~((word_t'(1) << TF_BIT) - word_t'(1));
    // bits past the end of the disk in the last word stay used forever
    localparam word_t PAD_MASK  = (PAD_BITS == 0) ? word_t'(0)
                                                  : ~((word_t'(1) << PAD_BITS) - word_t'(1));

    logic              req_op_reg;
    logic [BLOCK_W-1:0] req_idx_reg;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     rd_addr_q_reg;
    logic [BLOCK_W-1:0] pend_block_reg;
    logic              pend_status_reg;
    logic              m_valid_reg;
    logic [BLOCK_W-1:0] m_granted_block_reg;
    logic              m_status_reg;

    logic              rd_en_g;
    logic [AW-1:0]     wr_addr;
    word_t             wr_data;
    word_t             rd_data;
    word_t             tail_mask;
    logic [BIT_W-1:0]  hit_bit;
    logic [IW-1:0]     hit_index;
    logic [AW-1:0]     req_word;

    assign req_word  = AW'(req_idx_reg >> BIT_W);
    assign rd_en_g   = cmd.rd_en && (addr_reg <= AW'(LAST_WORD));
    assign tail_mask = (addr_reg == AW'(TF_WORD)) ? HEAD_MASK : '1;
    assign hit_index = {rd_addr_q_reg, hit_bit};

    // lowest clear bit of the word just read
    always_comb begin
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rd_data[i]) begin
                hit_bit = BIT_W'(i);
            end
        end
    end

    always_comb begin
        case (cmd.addr_op)
            ADDR_ZERO: addr_next = '0;
            ADDR_REQ:  addr_next = req_word;
            ADDR_TAIL: addr_next = AW'(TF_WORD);
            ADDR_INC:  addr_next = addr_reg + AW'(1);
            default:   addr_next = addr_reg;
        endcase
    end

    always_comb begin
        wr_addr = addr_reg;
        case (cmd.wr_sel)
            WR_CLEAR: wr_data = (addr_reg == AW'(LAST_WORD)) ? PAD_MASK : '0;
            WR_FREE:  wr_data = rd_data & ~(word_t'(1) << req_idx_reg[BIT_W-1:0]);
            WR_MARK0: wr_data = rd_data | word_t'(1);
            WR_TAIL:  wr_data = rd_data | tail_mask;
            WR_HIT: begin
                wr_data = rd_data | (word_t'(1) << hit_bit);
                wr_addr = rd_addr_q_reg;
            end
            default:  wr_data = rd_data;
        endcase
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en_g),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            addr_reg <= addr_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_op_reg  <= s_opcode;
            req_idx_reg <= s_block_index;
        end
        if (rd_en_g) begin
            rd_addr_q_reg <= addr_reg;
        end
        if (cmd.pend_load) begin
            case (cmd.pend_kind)
                PEND_HIT: begin
                    pend_block_reg  <= BLOCK_W'(hit_index);
                    pend_status_reg <= STATUS_OK;
                end
                PEND_FULL: begin
                    pend_block_reg  <= '0;
                    pend_status_reg <= STATUS_FULL;
                end
                default: begin
                    pend_block_reg  <= '0;
                    pend_status_reg <= STATUS_OK;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_granted_block_reg <= pend_block_reg;
            m_status_reg        <= pend_status_reg;
        end
    end

    assign sts.req_op       = req_op_reg;
    assign sts.req_in_range = 32'(req_idx_reg) < 32'(TOTAL_BLOCKS);
    assign sts.addr_last    = (addr_reg == AW'(LAST_WORD));
    assign sts.chk_last     = (rd_addr_q_reg == AW'(LAST_WORD));
    assign sts.word_full    = &rd_data;
    assign sts.bit0_set     = rd_data[0];
    assign sts.has_tail     = (RESERVED_TAIL > 0);
    assign sts.out_free     = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_granted_block = m_granted_block_reg;
    assign m_status        = m_status_reg;

endmodule

`default_nettype wire

### design/bba_ctrl.sv
// Controller state machine: clear sweep, free read-modify-write, marking and scan.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire bba_sts_t sts,
    output bba_cmd_t      cmd
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DECODE  = 4'd2;
    localparam logic [3:0] ST_F_RD    = 4'd3;
    localparam logic [3:0] ST_F_WR    = 4'd4;
    localparam logic [3:0] ST_A_RD0   = 4'd5;
    localparam logic [3:0] ST_A_CHK0  = 4'd6;
    localparam logic [3:0] ST_M_RD    = 4'd7;
    localparam logic [3:0] ST_M_WR    = 4'd8;
    localparam logic [3:0] ST_S_FIRST = 4'd9;
    localparam logic [3:0] ST_S_CHK   = 4'd10;
    localparam logic [3:0] ST_RESULT  = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.addr_op   = ADDR_HOLD;
        cmd.wr_sel    = WR_CLEAR;
        cmd.pend_kind = PEND_ZERO;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_CLEAR;
                if (sts.addr_last) begin
                    cmd.addr_op = ADDR_ZERO;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.addr_op = ADDR_INC;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.req_op == OP_ALLOC) begin
                    cmd.addr_op = ADDR_ZERO;
                    state_next  = ST_A_RD0;
                end else if (sts.req_in_range) begin
                    cmd.addr_op = ADDR_REQ;
                    state_next  = ST_F_RD;
                end else begin
                    cmd.pend_load = 1'b1;
                    cmd.pend_kind = PEND_ZERO;
                    state_next    = ST_RESULT;
                end
            end
            ST_F_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_F_WR;
            end
            ST_F_WR: begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = WR_FREE;
                cmd.pend_load = 1'b1;
                cmd.pend_kind = PEND_ZERO;
                state_next    = ST_RESULT;
            end
            ST_A_RD0: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_A_CHK0;
            end
            ST_A_CHK0: begin
                if (sts.bit0_set) begin
                    cmd.addr_op = ADDR_ZERO;
                    state_next  = ST_S_FIRST;
                end else begin
                    // block 0 was free: re-mark block 0, then the tail words
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_MARK0;
                    if (sts.has_tail) begin
                        cmd.addr_op = ADDR_TAIL;
                        state_next  = ST_M_RD;
                    end else begin
                        cmd.addr_op = ADDR_ZERO;
                        state_next  = ST_S_FIRST;
                    end
                end
            end
            ST_M_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_M_WR;
            end
            ST_M_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_TAIL;
                if (sts.addr_last) begin
                    cmd.addr_op = ADDR_ZERO;
                    state_next  = ST_S_FIRST;
                end else begin
                    cmd.addr_op = ADDR_INC;
                    state_next  = ST_M_RD;
                end
            end
            ST_S_FIRST: begin
                cmd.rd_en   = 1'b1;
                cmd.addr_op = ADDR_INC;
                state_next  = ST_S_CHK;
            end
            ST_S_CHK: begin
                // reads run one word ahead of the check
                if (!sts.word_full) begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_sel    = WR_HIT;
                    cmd.pend_load = 1'b1;
                    cmd.pend_kind = PEND_HIT;
                    state_next    = ST_RESULT;
                end else if (sts.chk_last) begin
                    cmd.pend_load = 1'b1;
                    cmd.pend_kind = PEND_FULL;
                    state_next    = ST_RESULT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.addr_op = ADDR_INC;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------------
//  input   | s_valid | s_ready | s_opcode, s_block_index
//  result  | m_valid | m_ready | m_granted_block, m_status
//
// One request at a time. A free is one read-modify-write of a
// 64-bit bitmap word. An allocate scans words at one per cycle through the single
// bitmap RAM read port, up to all WORDS words (WORDS = TOTAL_BLOCKS/64,
// 128 at the default); if block 0 is found free, it and each tail word are re-marked first.
// After reset a clearing sweep writes every bitmap word with s_ready low. A
// stalled result waits in the output register; the next request is taken
// meanwhile, and its own result waits for the register.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int TOTAL_BLOCKS  = 8192,
    parameter int RESERVED_TAIL = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_opcode,
    input  wire logic [BLOCK_W-1:0] s_block_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [BLOCK_W-1:0] m_granted_block,
    output logic                    m_status
);

    bba_cmd_t cmd;
    bba_sts_t sts;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bba_datapath #(
        .TOTAL_BLOCKS  (TOTAL_BLOCKS),
        .RESERVED_TAIL (RESERVED_TAIL)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_opcode        (s_opcode),
        .s_block_index   (s_block_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_block (m_granted_block),
        .m_status        (m_status)
    );

    // a full report never carries a block number
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_FULL) |-> (m_granted_block == '0))
        else $error("full result with nonzero block");

    // the bitmap port never reads and writes in the same cycle
    a_no_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && cmd.wr_en))
        else $error("bitmap read and write together");

    // one request in flight: no transfer in the cycle after one
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken back to back");

    // the output register is loaded only when it is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire
